// ----- design/wrs_pkg.sv -----
// Shared types and constants for the window rate statistics block.
// Used by the controller, the datapath and the top level.
package wrs_pkg;

   localparam int          MAX_WINDOW_DEF = 128;
   localparam logic [63:0] RATE_SCALE     = 64'd1_000_000_000_000;
   localparam logic [7:0]  WIN_RESET      = 8'd100;

   // arithmetic steps run after the first pass over the ring
   typedef enum logic [3:0] {
      OP_AVG_MUL,
      OP_AVG_DIV,
      OP_MEAN_DIV,
      OP_MIN_DIV,
      OP_MAX_DIV,
      OP_VAR_DIV,
      OP_SQRT,
      OP_SD_MUL,
      OP_DEN_MUL,
      OP_SD_DIV,
      OP_SQ_MUL
   } op_type;

   typedef enum logic [1:0] {
      UNIT_MUL,
      UNIT_DIV,
      UNIT_SQRT
   } unit_type;

   typedef struct packed {
      logic   capture;
      logic   rd_newest;
      logic   insert;
      logic   walk_init;
      logic   take1;
      logic   take2;
      logic   mul_start;
      logic   div_start;
      logic   sqrt_start;
      logic   store;
      logic   out_load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic count_ge2;
      logic idx_first;
      logic idx_last;
      logic walk_end;
      logic mul_done;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } status_type;

   function automatic unit_type op_unit(input op_type op);
      unit_type u;
      unique case (op)
         OP_AVG_MUL, OP_SD_MUL, OP_DEN_MUL, OP_SQ_MUL: u = UNIT_MUL;
         OP_SQRT:                                     u = UNIT_SQRT;
         default:                                     u = UNIT_DIV;
      endcase
      return u;
   endfunction

   function automatic logic [39:0] sat_rate(input logic [127:0] q);
      logic [39:0] r;
      if (q > {64'd0, RATE_SCALE}) r = RATE_SCALE[39:0];
      else r = q[39:0];
      return r;
   endfunction

   function automatic logic [127:0] sat_add(input logic [127:0] a, input logic [127:0] b);
      logic [128:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[128] ? {128{1'b1}} : s[127:0];
   endfunction

endpackage

// ----- design/wrs_mul.sv -----
// Iterative 64x64 -> 128 multiplier: one 32x32 partial product per cycle.
// Depends on nothing; used by the datapath.
module wrs_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] p
);

   logic [63:0]  a_ff, b_ff;
   logic [2:0]   cnt_ff;
   logic         busy_ff, pv_ff, done_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   psh_ff;
   logic [127:0] acc_ff;
   logic [31:0]  ah, bh;

   assign ah = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign bh = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            pv_ff   <= 1'b0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            pv_ff  <= !cnt_ff[2];
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff[2]) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         pp_ff  <= 64'(ah * bh);
         psh_ff <= 2'({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]});
         if (pv_ff) begin
            case (psh_ff)
               2'd0:    acc_ff <= acc_ff + {64'd0, pp_ff};
               2'd1:    acc_ff <= acc_ff + {32'd0, pp_ff, 32'd0};
               default: acc_ff <= acc_ff + {pp_ff, 64'd0};
            endcase
         end
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

// ----- design/wrs_div.sv -----
// 128-bit restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath. Divisor is never zero here.
module wrs_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] num,
   input  logic [127:0] den,
   output logic         done,
   output logic [127:0] q
);

   logic [127:0] q_ff, rem_ff, den_ff;
   logic [6:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [128:0] shifted, diff;
   logic         ge;

   assign shifted = {rem_ff, q_ff[127]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         // numerator bits leave the top while quotient bits enter the bottom
         q_ff   <= {q_ff[126:0], ge};
         rem_ff <= ge ? diff[127:0] : shifted[127:0];
      end
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule

// ----- design/wrs_sqrt.sv -----
// Integer floor square root of a 128-bit value, two radicand bits per cycle.
// Depends on nothing; used by the datapath.
module wrs_sqrt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] v,
   output logic         done,
   output logic [63:0]  r
);

   logic [127:0] v_ff;
   logic [67:0]  rem_ff;
   logic [63:0]  root_ff;
   logic [5:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [67:0]  rem_sh, trial;
   logic         ge;

   assign rem_sh = {rem_ff[65:0], v_ff[127:126]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= v;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         v_ff    <= {v_ff[125:0], 2'b00};
         rem_ff  <= ge ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[62:0], ge};
      end
   end

   assign done = done_ff;
   assign r    = root_ff;

endmodule

// ----- design/wrs_datapath.sv -----
// Datapath: timestamp ring memory, pointers, walk registers, arithmetic units
// and the result register. Depends on wrs_pkg, wrs_mul, wrs_div, wrs_sqrt.
module wrs_datapath
   import wrs_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_sample_valid,
   input  logic [63:0] req_source_time_ns,
   input  logic [63:0] req_local_time_ns,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_enough_data,
   output logic [7:0]  rsp_window_count,
   output logic [39:0] rsp_avg_rate_mhz,
   output logic [39:0] rsp_min_rate_mhz,
   output logic [39:0] rsp_max_rate_mhz,
   output logic [39:0] rsp_stddev_rate_mhz
);

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int EW = CW + 8;

   function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] head,
                                             input logic [CW-1:0] i);
      logic [AW:0] s;
      s = {1'b0, head} + (AW + 1)'(i);
      if (s >= (AW + 1)'(MAX_WINDOW)) s = s - (AW + 1)'(MAX_WINDOW);
      return s[AW-1:0];
   endfunction

   logic [63:0]   mem [MAX_WINDOW];
   logic [63:0]   rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    win_ff;
   logic [CW-1:0] win_eff;
   logic [EW-1:0] win_ext;

   logic [63:0]   t_ff;
   logic          sv_ff, acc_ff, take;
   logic [CW-1:0] idx_ff, cnt_m1;
   logic [63:0]   prev_ff, first_ff, last_ff, lo_ff, hi_ff, m_ff, d_ff, span, n64, iv;
   logic [127:0]  var_ff, num_ff;
   logic [39:0]   avg_ff, mn_ff, mx_ff, sd_ff;

   logic          rv_ff, racc_ff, rhas_ff;
   logic [7:0]    rcnt_ff;
   logic [39:0]   ravg_ff, rmn_ff, rmx_ff, rsd_ff;
   logic [EW-1:0] count_ext;

   logic [63:0]   mul_a, mul_b;
   logic [127:0]  mul_p, div_num, div_den, div_q;
   logic [63:0]   sq_r;
   logic          mul_done, div_done, sqrt_done;

   // effective window, clamped to [2, MAX_WINDOW]
   always_comb begin
      win_ext = {{CW{1'b0}}, win_ff};
      if (win_ext < EW'(2)) win_ext = EW'(2);
      else if (win_ext > EW'(MAX_WINDOW)) win_ext = EW'(MAX_WINDOW);
      win_eff = win_ext[CW-1:0];
   end

   assign cnt_m1 = count_ff - CW'(1);
   assign n64    = 64'(cnt_m1);
   assign span   = last_ff - first_ff;
   assign iv     = rd_data_ff - prev_ff;

   assign rd_addr = cmd.rd_newest ? ((count_ff == '0) ? '0 : ring_at(head_ff, cnt_m1))
                                  : ring_at(head_ff, idx_ff);
   // when the ring is full this lands on the oldest entry
   assign wr_addr = ring_at(head_ff, count_ff);
   assign take    = sv_ff && ((count_ff == '0) || (t_ff > rd_data_ff));
   assign wr_en   = cmd.insert && take;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= t_ff;
      rd_data_ff <= mem[rd_addr];
   end

   // pointer update on insert, with trim to the current window
   always_comb begin
      logic [AW-1:0] h1;
      logic [CW-1:0] c1;
      h1 = head_ff;
      c1 = count_ff;
      if (count_ff == CW'(MAX_WINDOW)) h1 = ring_at(head_ff, CW'(1));
      else c1 = count_ff + CW'(1);
      head_in  = h1;
      count_in = c1;
      if (c1 > win_eff) begin
         head_in  = ring_at(h1, c1 - win_eff);
         count_in = win_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         win_ff   <= WIN_RESET;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) win_ff <= csr_wr_data;
         if (wr_en) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         if (cmd.out_load) rv_ff <= 1'b1;
         else if (!rsp_stall) rv_ff <= 1'b0;
      end
   end

   // operand selection per arithmetic step
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      div_num = '0;
      div_den = 128'd1;
      case (cmd.op)
         OP_AVG_MUL:  begin mul_a = RATE_SCALE; mul_b = n64; end
         OP_SQ_MUL:   begin mul_a = d_ff; mul_b = d_ff; end
         OP_SD_MUL:   begin mul_a = sq_r; mul_b = RATE_SCALE; end
         OP_DEN_MUL:  begin mul_a = m_ff; mul_b = m_ff; end
         OP_AVG_DIV:  begin div_num = mul_p; div_den = {64'd0, span}; end
         OP_MEAN_DIV: begin div_num = {64'd0, span}; div_den = {64'd0, n64}; end
         OP_MIN_DIV:  begin div_num = {64'd0, RATE_SCALE}; div_den = {64'd0, hi_ff}; end
         OP_MAX_DIV:  begin div_num = {64'd0, RATE_SCALE}; div_den = {64'd0, lo_ff}; end
         OP_VAR_DIV:  begin div_num = var_ff; div_den = {64'd0, n64}; end
         OP_SD_DIV:   begin div_num = num_ff; div_den = mul_p; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t_ff  <= (req_source_time_ns != 64'd0) ? req_source_time_ns : req_local_time_ns;
         sv_ff <= req_sample_valid;
      end
      if (cmd.insert) acc_ff <= take;
      if (cmd.walk_init) begin
         idx_ff <= '0;
         lo_ff  <= '1;
         hi_ff  <= '0;
         var_ff <= '0;
      end
      if (cmd.take1) begin
         idx_ff  <= idx_ff + CW'(1);
         prev_ff <= rd_data_ff;
         last_ff <= rd_data_ff;
         if (idx_ff == '0) first_ff <= rd_data_ff;
         else begin
            if (iv < lo_ff) lo_ff <= iv;
            if (iv > hi_ff) hi_ff <= iv;
         end
      end
      if (cmd.take2) begin
         idx_ff  <= idx_ff + CW'(1);
         prev_ff <= rd_data_ff;
         d_ff    <= (iv >= m_ff) ? iv - m_ff : m_ff - iv;
      end
      if (cmd.store) begin
         case (cmd.op)
            OP_AVG_DIV:  avg_ff <= sat_rate(div_q);
            OP_MEAN_DIV: m_ff   <= div_q[63:0];
            OP_MIN_DIV:  mn_ff  <= sat_rate(div_q);
            OP_MAX_DIV:  mx_ff  <= sat_rate(div_q);
            OP_SQ_MUL:   var_ff <= sat_add(var_ff, mul_p);
            OP_SD_MUL:   num_ff <= mul_p;
            OP_SD_DIV:   sd_ff  <= sat_rate(div_q);
            default: ;
         endcase
      end
   end

   assign count_ext = {8'd0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         racc_ff <= acc_ff;
         rhas_ff <= status.count_ge2;
         rcnt_ff <= count_ext[7:0];
         ravg_ff <= status.count_ge2 ? avg_ff : '0;
         rmn_ff  <= status.count_ge2 ? mn_ff : '0;
         rmx_ff  <= status.count_ge2 ? mx_ff : '0;
         rsd_ff  <= status.count_ge2 ? sd_ff : '0;
      end
   end

   wrs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   wrs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .q     (div_q)
   );

   wrs_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .v     (div_q),
      .done  (sqrt_done),
      .r     (sq_r)
   );

   assign status.count_ge2 = count_ff >= CW'(2);
   assign status.idx_first = idx_ff == '0;
   assign status.idx_last  = idx_ff == cnt_m1;
   assign status.walk_end  = idx_ff == count_ff;
   assign status.mul_done  = mul_done;
   assign status.div_done  = div_done;
   assign status.sqrt_done = sqrt_done;
   assign status.out_free  = !rv_ff || !rsp_stall;

   assign rsp_valid           = rv_ff;
   assign rsp_accepted        = racc_ff;
   assign rsp_enough_data     = rhas_ff;
   assign rsp_window_count    = rcnt_ff;
   assign rsp_avg_rate_mhz    = ravg_ff;
   assign rsp_min_rate_mhz    = rmn_ff;
   assign rsp_max_rate_mhz    = rmx_ff;
   assign rsp_stddev_rate_mhz = rsd_ff;

endmodule

// ----- design/wrs_ctrl.sv -----
// Controller state machine: sequences insert, the two ring passes and the
// arithmetic steps. Depends on wrs_pkg; drives the datapath by command word.
module wrs_ctrl
   import wrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_DEC     = 13'b0000000000010,
      S_CHK     = 13'b0000000000100,
      S_W1_RD   = 13'b0000000001000,
      S_W1_DAT  = 13'b0000000010000,
      S_OP_ST   = 13'b0000000100000,
      S_OP_WT   = 13'b0000001000000,
      S_W2_INIT = 13'b0000010000000,
      S_W2_RD   = 13'b0000100000000,
      S_W2_DAT  = 13'b0001000000000,
      S_SQ_ST   = 13'b0010000000000,
      S_SQ_WT   = 13'b0100000000000,
      S_OUT     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   unit_type  unit;
   logic      unit_done;

   function automatic op_type next_op(input op_type op);
      op_type n;
      case (op)
         OP_AVG_MUL:  n = OP_AVG_DIV;
         OP_AVG_DIV:  n = OP_MEAN_DIV;
         OP_MEAN_DIV: n = OP_MIN_DIV;
         OP_MIN_DIV:  n = OP_MAX_DIV;
         OP_VAR_DIV:  n = OP_SQRT;
         OP_SQRT:     n = OP_SD_MUL;
         OP_SD_MUL:   n = OP_DEN_MUL;
         OP_DEN_MUL:  n = OP_SD_DIV;
         default:     n = OP_AVG_MUL;
      endcase
      return n;
   endfunction

   assign unit = op_unit(op_ff);

   always_comb begin
      unique case (unit)
         UNIT_MUL:  unit_done = status.mul_done;
         UNIT_SQRT: unit_done = status.sqrt_done;
         default:   unit_done = status.div_done;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.rd_newest = 1'b1;
            cmd.capture   = req_valid;
            if (req_valid) state_in = S_DEC;
         end
         S_DEC: begin
            cmd.insert = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            cmd.walk_init = 1'b1;
            state_in      = status.count_ge2 ? S_W1_RD : S_OUT;
         end
         S_W1_RD: state_in = S_W1_DAT;
         S_W1_DAT: begin
            cmd.take1 = 1'b1;
            if (status.idx_last) begin
               op_in    = OP_AVG_MUL;
               state_in = S_OP_ST;
            end else begin
               state_in = S_W1_RD;
            end
         end
         S_OP_ST: begin
            cmd.mul_start  = unit == UNIT_MUL;
            cmd.div_start  = unit == UNIT_DIV;
            cmd.sqrt_start = unit == UNIT_SQRT;
            state_in       = S_OP_WT;
         end
         S_OP_WT: begin
            if (unit_done) begin
               cmd.store = 1'b1;
               if (op_ff == OP_MAX_DIV) begin
                  state_in = S_W2_INIT;
               end else if (op_ff == OP_SD_DIV) begin
                  state_in = S_OUT;
               end else begin
                  op_in    = next_op(op_ff);
                  state_in = S_OP_ST;
               end
            end
         end
         S_W2_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_W2_RD;
         end
         S_W2_RD: state_in = S_W2_DAT;
         S_W2_DAT: begin
            cmd.take2 = 1'b1;
            state_in  = status.idx_first ? S_W2_RD : S_SQ_ST;
         end
         S_SQ_ST: begin
            cmd.op        = OP_SQ_MUL;
            cmd.mul_start = 1'b1;
            state_in      = S_SQ_WT;
         end
         S_SQ_WT: begin
            cmd.op = OP_SQ_MUL;
            if (status.mul_done) begin
               cmd.store = 1'b1;
               if (status.walk_end) begin
                  op_in    = OP_VAR_DIV;
                  state_in = S_OP_ST;
               end else begin
                  state_in = S_W2_RD;
               end
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_AVG_MUL;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

// ----- design/window_rate_statistics_top.sv -----
// With fewer than two stored timestamps the ring passes and arithmetic are skipped;
// otherwise the time grows with the N stored timestamps and is dominated by the
// bit-per-cycle 128-bit divider (six divisions), the square root and the
// variance step per interval. One word is in work at a time; the next is taken once
// the controller is back in idle, as the result is loaded into the output register.
// Synchronous reset empties the ring and sets the window size back to 100.
module window_rate_statistics_top
   import wrs_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_sample_valid,
   input  logic [63:0] req_source_time_ns,
   input  logic [63:0] req_local_time_ns,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_enough_data,
   output logic [7:0]  rsp_window_count,
   output logic [39:0] rsp_avg_rate_mhz,
   output logic [39:0] rsp_min_rate_mhz,
   output logic [39:0] rsp_max_rate_mhz,
   output logic [39:0] rsp_stddev_rate_mhz,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   wrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wrs_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sample_valid    (req_sample_valid),
      .req_source_time_ns  (req_source_time_ns),
      .req_local_time_ns   (req_local_time_ns),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_enough_data     (rsp_enough_data),
      .rsp_window_count    (rsp_window_count),
      .rsp_avg_rate_mhz    (rsp_avg_rate_mhz),
      .rsp_min_rate_mhz    (rsp_min_rate_mhz),
      .rsp_max_rate_mhz    (rsp_max_rate_mhz),
      .rsp_stddev_rate_mhz (rsp_stddev_rate_mhz)
   );

endmodule
